// ===== design/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types, codes and helpers for the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int NameW = 200;
  localparam int IdW = 20;
  localparam int GradeW = 10;
  localparam int TakenW = 7;
  localparam logic [TakenW-1:0] MaxOut = 7'd64;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_LIST = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [NameW-1:0] name;
    logic [IdW-1:0] id;
    logic [GradeW-1:0] grade;
  } rec_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_BSRCH = 5'b00100,
    S_FETCH = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  // zero bytes past the character limit and after the first zero byte
  function automatic logic [NameW-1:0] norm_name(input logic [NameW-1:0] raw,
                                                 input int unsigned nchars);
    logic [NameW-1:0] n;
    logic ended;
    logic [7:0] b;
    n = '0;
    ended = 1'b0;
    for (int k = 0; k < 25; k++) begin
      b = raw[NameW-1-8*k -: 8];
      if (k >= nchars || ended) b = 8'd0;
      if (b == 8'd0) ended = 1'b1;
      n[NameW-1-8*k -: 8] = b;
    end
    return n;
  endfunction

endpackage

// ===== design/srt_cell.sv =====
// ----------------------------------------------------------------------------
// srt_cell
// One table slot: holds a record and passes it on to the next slot on shift.
// ----------------------------------------------------------------------------
module srt_cell (
  input  logic          clk_i,
  input  logic          shift_i,
  input  srt_pkg::rec_t rec_i,
  output srt_pkg::rec_t rec_o
);

  srt_pkg::rec_t rec_q;

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

// ===== design/sorted_record_table.sv =====
// ----------------------------------------------------------------------------
// sorted_record_table
// Record table kept sorted by name then id, stored in a ring of cells.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                     tuser     tlast
// s_axis    in   name a, b, c, d, student_id, grade_tenths req_type  -
// m_axis    out  position, found_id, found_grade           status    last
//
// The ring rotates one slot a cycle while walking or fetching, unless a list
// result stalls it while the output register is held; a full turn of DEPTH
// slots restores the table. Insert and list turn once, then emit; lookup adds
// up to log2(DEPTH) + 1 search steps and a second turn when found; clear and
// a full insert just emit. Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_record_table #(
  parameter int DEPTH = 64,
  parameter int NAME_CHARS = 25
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // name_bytes_0_7, name_bytes_8_15, name_bytes_16_23, name_byte_24,
  // student_id, grade_tenths, zero fill
  input  logic [231:0] s_axis_tdata,
  // req_type
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // position, found_id, found_grade, zero fill
  output logic [39:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  srt_pkg::rec_t chain [DEPTH];
  srt_pkg::rec_t head, tail;
  logic shift;

  srt_pkg::state_e state_q, state_d;
  logic [1:0] op_q, op_d;
  srt_pkg::rec_t key_q, key_d, hold_q, hold_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] k_q, k_d, pos_q, pos_d;
  logic [IDX_W-1:0] first_q, first_d, last_q, last_d, lo_q, lo_d, hi_q, hi_d;
  logic ins_q, ins_d, have_q, have_d, pval_q, pval_d;
  logic [srt_pkg::TakenW-1:0] taken_q, taken_d;
  logic [1:0] rst_q, rst_d;
  logic [srt_pkg::IdW-1:0] rid_q, rid_d;
  logic [srt_pkg::GradeW-1:0] rgr_q, rgr_d;

  logic out_valid_q, out_load, out_last;
  logic [39:0] out_data_q;
  logic [1:0] out_user_q;
  logic out_last_q;

  logic out_free, in_tab, last_step, lt, name_eq, full_eq, list_hit;
  logic [IDX_W:0] mid_sum;
  logic [IDX_W-1:0] mid;
  logic [IDX_W+5:0] pos_ext;

  // ring of cells, slot DEPTH-1 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      srt_cell u_cell (.clk_i(clk_i), .shift_i(shift), .rec_i(tail), .rec_o(chain[i]));
    end else begin : g_rest
      srt_cell u_cell (.clk_i(clk_i), .shift_i(shift), .rec_i(chain[i-1]),
                       .rec_o(chain[i]));
    end
  end

  assign head = chain[DEPTH-1];

  // head versus key
  assign lt = {head.name, head.id} < {key_q.name, key_q.id};
  assign name_eq = head.name == key_q.name;
  assign full_eq = name_eq && (head.id == key_q.id);
  assign in_tab = CNT_W'(k_q) < count_q;
  assign last_step = k_q == IDX_W'(DEPTH - 1);
  assign out_free = !out_valid_q || m_axis_tready;
  assign list_hit = name_eq && in_tab && (taken_q < srt_pkg::MaxOut);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = mid_sum[IDX_W:1];

  // sequencer
  always_comb begin
    state_d = state_q; op_d = op_q; key_d = key_q; hold_d = hold_q;
    count_d = count_q; k_d = k_q; pos_d = pos_q; first_d = first_q;
    last_d = last_q; lo_d = lo_q; hi_d = hi_q; ins_d = ins_q;
    have_d = have_q; pval_d = pval_q; taken_d = taken_q;
    rst_d = rst_q; rid_d = rid_q; rgr_d = rgr_q;
    shift = 1'b0; tail = head; out_load = 1'b0; out_last = 1'b1;
    case (state_q)
      srt_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          key_d.name = srt_pkg::norm_name({s_axis_tdata[63:0], s_axis_tdata[127:64],
                                           s_axis_tdata[191:128], s_axis_tdata[199:192]},
                                          NAME_CHARS);
          key_d.id = s_axis_tdata[219:200];
          key_d.grade = s_axis_tdata[229:220];
          op_d = s_axis_tuser;
          k_d = '0; ins_d = 1'b0; have_d = 1'b0; pval_d = 1'b0; taken_d = '0;
          rst_d = srt_pkg::ST_OK; pos_d = '0; rid_d = '0; rgr_d = '0;
          case (s_axis_tuser)
            srt_pkg::REQ_INSERT: begin
              if (count_q == CNT_W'(DEPTH)) begin
                rst_d = srt_pkg::ST_FULL;
                state_d = srt_pkg::S_EMIT;
              end else begin
                state_d = srt_pkg::S_WALK;
              end
            end
            srt_pkg::REQ_CLEAR: begin
              count_d = '0;
              state_d = srt_pkg::S_EMIT;
            end
            default: state_d = srt_pkg::S_WALK;
          endcase
        end
      end
      srt_pkg::S_WALK: begin
        if (!(op_q == srt_pkg::REQ_LIST && list_hit && pval_q && !out_free)) begin
          shift = 1'b1;
          k_d = k_q + IDX_W'(1);
          case (op_q)
            srt_pkg::REQ_INSERT: begin
              if (!ins_q && (!in_tab || !lt)) begin
                tail = key_q; hold_d = head; ins_d = 1'b1; pos_d = k_q;
              end else if (ins_q) begin
                tail = hold_q; hold_d = head;
              end
            end
            srt_pkg::REQ_LOOKUP: begin
              if (full_eq && in_tab) begin
                if (!have_q) first_d = k_q;
                last_d = k_q;
                have_d = 1'b1;
              end
            end
            default: begin
              if (list_hit) begin
                if (pval_q) begin
                  out_load = 1'b1;
                  out_last = 1'b0;
                end
                pos_d = k_q; rid_d = head.id; rgr_d = head.grade;
                pval_d = 1'b1;
                taken_d = taken_q + srt_pkg::TakenW'(1);
              end
            end
          endcase
          // end of one full turn
          if (last_step) begin
            k_d = '0;
            case (op_q)
              srt_pkg::REQ_INSERT: begin
                count_d = count_q + CNT_W'(1);
                rid_d = key_q.id; rgr_d = key_q.grade;
                state_d = srt_pkg::S_EMIT;
              end
              srt_pkg::REQ_LOOKUP: begin
                if (have_d) begin
                  lo_d = '0;
                  hi_d = IDX_W'(count_q - CNT_W'(1));
                  state_d = srt_pkg::S_BSRCH;
                end else begin
                  rst_d = srt_pkg::ST_NOT_FOUND;
                  state_d = srt_pkg::S_EMIT;
                end
              end
              default: begin
                if (!pval_d) rst_d = srt_pkg::ST_NOT_FOUND;
                state_d = srt_pkg::S_EMIT;
              end
            endcase
          end
        end
      end
      // replay the probes against the range of matching slots
      srt_pkg::S_BSRCH: begin
        if (mid < first_q) begin
          lo_d = mid + IDX_W'(1);
        end else if (mid > last_q) begin
          hi_d = mid - IDX_W'(1);
        end else begin
          pos_d = mid;
          k_d = '0;
          state_d = srt_pkg::S_FETCH;
        end
      end
      // second turn picks up the grade at the probed slot
      srt_pkg::S_FETCH: begin
        shift = 1'b1;
        k_d = k_q + IDX_W'(1);
        if (k_q == pos_q) rgr_d = head.grade;
        if (last_step) begin
          k_d = '0;
          rid_d = key_q.id;
          state_d = srt_pkg::S_EMIT;
        end
      end
      srt_pkg::S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d = srt_pkg::S_IDLE;
        end
      end
      default: state_d = srt_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srt_pkg::S_IDLE;
      count_q <= '0;
      ins_q <= 1'b0;
      have_q <= 1'b0;
      pval_q <= 1'b0;
      taken_q <= '0;
      k_q <= '0;
      op_q <= srt_pkg::REQ_INSERT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ins_q <= ins_d;
      have_q <= have_d;
      pval_q <= pval_d;
      taken_q <= taken_d;
      k_q <= k_d;
      op_q <= op_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  assign pos_ext = {6'd0, pos_q};

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d; hold_q <= hold_d; pos_q <= pos_d;
    first_q <= first_d; last_q <= last_d; lo_q <= lo_d; hi_q <= hi_d;
    rst_q <= rst_d; rid_q <= rid_d; rgr_q <= rgr_d;
    if (out_load) begin
      out_data_q <= {4'd0, rgr_q, rid_q, pos_ext[5:0]};
      out_user_q <= rst_q;
      out_last_q <= out_last;
    end
  end

  assign s_axis_tready = state_q == srt_pkg::S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;
  assign m_axis_tlast = out_last_q;

endmodule

// ===== design/srt_checker.sv =====
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks for the sorted record table, bound to the top level.
// ----------------------------------------------------------------------------
module srt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  // a held result stays up
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // failure results carry no record
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != srt_pkg::ST_OK |->
      m_axis_tdata == 40'd0 && m_axis_tlast)
    else $error("failure result not empty");

  // no undefined status code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= srt_pkg::ST_FULL)
    else $error("bad status code");

endmodule

bind sorted_record_table srt_checker u_srt_checker (.*);
